// ===== sv/pev_pkg.sv =====
// pev_pkg: types, codes and the microcode table of the polynomial evaluation engine
// used by pev_mul, pev_chk and polynomial_eval_engine; no dependencies
package pev_pkg;

  // width of one multiplier digit
  localparam int unsigned DIG_W  = 32;
  localparam int unsigned STEP_W = 4;

  typedef struct packed {
    logic [1:0]         mode;
    logic [3:0]         term_index;
    logic signed [31:0] coef_value;
    logic signed [31:0] point_x;
    logic signed [31:0] scale_factor;
  } pev_in_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic               status;
  } pev_out_t;

  typedef enum logic [1:0] {
    MODE_WRITE = 2'd0,
    MODE_READ  = 2'd1,
    MODE_SCALE = 2'd2,
    MODE_EVAL  = 2'd3
  } mode_e;

  // program addresses
  typedef enum logic [STEP_W-1:0] {
    ST_IDLE = 4'd0,
    ST_WR   = 4'd1,
    ST_RD0  = 4'd2,
    ST_RD1  = 4'd3,
    ST_SC0  = 4'd4,
    ST_SC1  = 4'd5,
    ST_SC2  = 4'd6,
    ST_SCD  = 4'd7,
    ST_EV0  = 4'd8,
    ST_EV1  = 4'd9,
    ST_EV2  = 4'd10,
    ST_EV3  = 4'd11,
    ST_EVD  = 4'd12
  } step_e;

  // condition that keeps a step waiting
  typedef enum logic [1:0] {
    H_NONE,
    H_IN,
    H_MUL,
    H_OUT
  } hold_e;

  // sequencing: fall through, jump, dispatch on mode, conditional jumps
  typedef enum logic [2:0] {
    J_NEXT,
    J_GO,
    J_MODE,
    J_PTR_ZERO,
    J_PTR_NZ,
    J_PTR_NE_DEG
  } jc_e;

  typedef enum logic [2:0] {
    RD_NONE,
    RD_IDX,
    RD_ZERO,
    RD_DEG,
    RD_PTR_INC,
    RD_PTR_DEC
  } rd_e;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_CMD,
    WR_MUL
  } wr_e;

  typedef enum logic {
    MS_SCALE,
    MS_HORNER
  } ms_e;

  typedef enum logic [1:0] {
    ACC_KEEP,
    ACC_LD,
    ACC_MAC
  } acc_e;

  typedef enum logic [2:0] {
    PTR_KEEP,
    PTR_ZERO,
    PTR_DEG,
    PTR_INC,
    PTR_DEC
  } ptr_e;

  typedef enum logic [1:0] {
    EM_NONE,
    EM_ZERO,
    EM_READ,
    EM_ACC
  } em_e;

  typedef struct packed {
    hold_e hold;
    jc_e   jc;
    step_e target;
    logic  ld_cmd;
    rd_e   rd;
    wr_e   wr;
    logic  mul_go;
    ms_e   mul_src;
    acc_e  acc;
    ptr_e  ptr;
    em_e   emit;
  } ctrl_t;

  localparam ctrl_t CTRL_NOP = '{
    hold:    H_NONE,
    jc:      J_NEXT,
    target:  ST_IDLE,
    ld_cmd:  1'b0,
    rd:      RD_NONE,
    wr:      WR_NONE,
    mul_go:  1'b0,
    mul_src: MS_SCALE,
    acc:     ACC_KEEP,
    ptr:     PTR_KEEP,
    emit:    EM_NONE
  };

  // microcode store
  function automatic ctrl_t ucode(step_e s);
    ctrl_t c;
    c = CTRL_NOP;
    case (s)
      ST_IDLE: begin
        c.hold   = H_IN;
        c.jc     = J_MODE;
        c.ld_cmd = 1'b1;
      end
      ST_WR: begin
        c.hold = H_OUT;
        c.wr   = WR_CMD;
        c.emit = EM_ZERO;
        c.jc   = J_GO;
      end
      ST_RD0: begin
        c.rd = RD_IDX;
      end
      ST_RD1: begin
        c.hold = H_OUT;
        c.emit = EM_READ;
        c.jc   = J_GO;
      end
      ST_SC0: begin
        c.rd  = RD_ZERO;
        c.ptr = PTR_ZERO;
      end
      ST_SC1: begin
        c.mul_go  = 1'b1;
        c.mul_src = MS_SCALE;
      end
      ST_SC2: begin
        c.hold   = H_MUL;
        c.wr     = WR_MUL;
        c.rd     = RD_PTR_INC;
        c.ptr    = PTR_INC;
        c.jc     = J_PTR_NE_DEG;
        c.target = ST_SC1;
      end
      ST_SCD: begin
        c.hold = H_OUT;
        c.emit = EM_ZERO;
        c.jc   = J_GO;
      end
      ST_EV0: begin
        c.rd  = RD_DEG;
        c.ptr = PTR_DEG;
      end
      ST_EV1: begin
        c.acc    = ACC_LD;
        c.rd     = RD_PTR_DEC;
        c.ptr    = PTR_DEC;
        c.jc     = J_PTR_ZERO;
        c.target = ST_EVD;
      end
      ST_EV2: begin
        c.mul_go  = 1'b1;
        c.mul_src = MS_HORNER;
      end
      ST_EV3: begin
        c.hold   = H_MUL;
        c.acc    = ACC_MAC;
        c.rd     = RD_PTR_DEC;
        c.ptr    = PTR_DEC;
        c.jc     = J_PTR_NZ;
        c.target = ST_EV2;
      end
      ST_EVD: begin
        c.hold = H_OUT;
        c.emit = EM_ACC;
        c.jc   = J_GO;
      end
      default: begin
        c.jc = J_GO;
      end
    endcase
    return c;
  endfunction

endpackage

// ===== sv/pev_ram.sv =====
// pev_ram: generic single-write, single-read RAM with registered read data
// no package dependencies
module pev_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/pev_mul.sv =====
// pev_mul: wrapping multiplier, one 32x32 partial product per cycle
// depends on pev_pkg (digit width)
module pev_mul import pev_pkg::*; #(
  parameter int unsigned W = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         go_i,
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  output logic         busy_o,
  output logic [W-1:0] res_o
);

  localparam int unsigned ND   = (W + DIG_W - 1) / DIG_W;
  localparam int unsigned PW   = ND * DIG_W;
  localparam int unsigned PPW  = 2 * DIG_W;
  localparam int unsigned CNTW = (ND > 1) ? $clog2(ND) : 1;
  localparam logic [CNTW-1:0] LAST = CNTW'(ND - 1);

  logic [PW-1:0]    a_q, b_q, a_ext, b_ext;
  logic [DIG_W-1:0] da, db;
  logic [PPW-1:0]   prod, p_q;
  logic [CNTW-1:0]  sh_q, sh_d;
  logic [CNTW-1:0]  i_q, i_d, j_q, j_d;
  logic             busy_q, busy_d;
  logic [W-1:0]     acc_q;
  logic [PW-1:0]    pp_sh;

  assign a_ext = PW'(a_i);
  assign b_ext = PW'(b_i);

  // first digit pair straight from the operands, the rest from the held copies
  always_comb begin
    if (go_i) begin
      da   = a_ext[DIG_W-1:0];
      db   = b_ext[DIG_W-1:0];
      sh_d = '0;
    end else begin
      da   = a_q[i_q*DIG_W +: DIG_W];
      db   = b_q[j_q*DIG_W +: DIG_W];
      sh_d = CNTW'(i_q + j_q);
    end
  end

  assign prod  = PPW'(da) * PPW'(db);
  assign pp_sh = PW'(p_q) << (DIG_W * sh_q);
  assign res_o = acc_q + pp_sh[W-1:0];
  assign busy_o = busy_q;

  // walk the digit pairs whose weight stays below the word
  always_comb begin
    busy_d = busy_q;
    i_d    = i_q;
    j_d    = j_q;
    if (go_i) begin
      busy_d = (ND > 1);
      i_d    = '0;
      j_d    = CNTW'(1);
    end else if (busy_q) begin
      if (CNTW'(i_q + j_q) == LAST) begin
        if (i_q == LAST) begin
          busy_d = 1'b0;
        end else begin
          i_d = i_q + CNTW'(1);
          j_d = '0;
        end
      end else begin
        j_d = j_q + CNTW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      i_q    <= '0;
      j_q    <= '0;
    end else begin
      busy_q <= busy_d;
      i_q    <= i_d;
      j_q    <= j_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_i) begin
      a_q   <= a_ext;
      b_q   <= b_ext;
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= res_o;
    end
    if (go_i || busy_q) begin
      p_q  <= prod;
      sh_q <= sh_d;
    end
  end

endmodule

// ===== sv/polynomial_eval_engine.sv =====
// polynomial_eval_engine: microcoded coefficient store with scale and evaluate
// depends on pev_pkg, pev_ram, pev_mul
//
//  channel | direction | handshake                  | payload
//  in      | input     | in_valid_i / in_ready_o    | in_data_i   (pev_in_t)
//  out     | output    | out_valid_o / out_ready_i  | out_data_o  (pev_out_t)
//
// one command at a time; for COEF_WIDTH above 32 the shared multiplier needs extra
// partial products for every term that it multiplies
// the term loops are bound by the shared multiplier and the single read port
// reset clears the degree, the valid bits of the store and the sequencer
// a result held in the output register stalls only the final step of the next command
module polynomial_eval_engine import pev_pkg::*; #(
  parameter int unsigned MAX_DEGREE = 15,
  parameter int unsigned COEF_WIDTH = 32
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  pev_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output pev_out_t out_data_o
);

  localparam int unsigned DEPTH = MAX_DEGREE + 1;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = (AW > 4) ? AW : 4;
  localparam int unsigned VN    = 1 << AW;

  function automatic logic [COEF_WIDTH-1:0] to_coef(logic [31:0] v);
    return COEF_WIDTH'(signed'(v));
  endfunction

  function automatic logic [31:0] coef_to_out(logic [COEF_WIDTH-1:0] c);
    return 32'(signed'(c));
  endfunction

  ctrl_t               ctl;
  step_e               pc_q, pc_d, pc_inc, mode_tgt;
  logic                hold, act;
  pev_in_t             cmd_q;
  logic [AW-1:0]       deg_q, ptr_q, ptr_d;
  logic [COEF_WIDTH-1:0] acc_q, acc_d;
  logic [VN-1:0]       vld_q;
  logic                rvld_q;
  pev_out_t            out_q, out_d;
  logic                out_vld_q;

  logic [CW-1:0]       idx_ext, deg_ext;
  logic [AW-1:0]       idx_addr;
  logic                idx_ok, rd_err;

  logic                we, re;
  logic [AW-1:0]       waddr, raddr;
  logic [COEF_WIDTH-1:0] wdata, rdata, rdata_eff;

  logic                mul_go, mul_busy;
  logic [COEF_WIDTH-1:0] mul_a, mul_b, mul_res;

  assign ctl = ucode(pc_q);

  assign idx_ext  = CW'(cmd_q.term_index);
  assign deg_ext  = CW'(deg_q);
  assign idx_addr = idx_ext[AW-1:0];
  assign idx_ok   = idx_ext <= CW'(MAX_DEGREE);
  assign rd_err   = idx_ext > deg_ext;

  // entries never written read as zero
  assign rdata_eff = rvld_q ? rdata : '0;

  always_comb begin
    case (hold_e'(ctl.hold))
      H_IN:    hold = !in_valid_i;
      H_MUL:   hold = mul_busy;
      H_OUT:   hold = out_vld_q && !out_ready_i;
      default: hold = 1'b0;
    endcase
  end

  assign act        = !hold;
  assign in_ready_o = (ctl.hold == H_IN);

  // next step
  assign pc_inc = step_e'(pc_q + STEP_W'(1));

  always_comb begin
    case (mode_e'(in_data_i.mode))
      MODE_WRITE: mode_tgt = ST_WR;
      MODE_READ:  mode_tgt = ST_RD0;
      MODE_SCALE: mode_tgt = ST_SC0;
      default:    mode_tgt = ST_EV0;
    endcase
  end

  always_comb begin
    pc_d = pc_q;
    if (act) begin
      case (ctl.jc)
        J_NEXT:       pc_d = pc_inc;
        J_GO:         pc_d = ctl.target;
        J_MODE:       pc_d = mode_tgt;
        J_PTR_ZERO:   pc_d = (ptr_q == '0) ? ctl.target : pc_inc;
        J_PTR_NZ:     pc_d = (ptr_q != '0) ? ctl.target : pc_inc;
        J_PTR_NE_DEG: pc_d = (ptr_q != deg_q) ? ctl.target : pc_inc;
        default:      pc_d = ST_IDLE;
      endcase
    end
  end

  // datapath controls
  always_comb begin
    we    = 1'b0;
    waddr = ptr_q;
    wdata = mul_res;
    case (ctl.wr)
      WR_CMD: begin
        we    = act && idx_ok;
        waddr = idx_addr;
        wdata = to_coef(cmd_q.coef_value);
      end
      WR_MUL: we = act;
      default: we = 1'b0;
    endcase

    re = act && (ctl.rd != RD_NONE);
    case (ctl.rd)
      RD_IDX:     raddr = idx_addr;
      RD_DEG:     raddr = deg_q;
      RD_PTR_INC: raddr = ptr_q + AW'(1);
      RD_PTR_DEC: raddr = ptr_q - AW'(1);
      default:    raddr = '0;
    endcase

    mul_go = act && ctl.mul_go;
    if (ctl.mul_src == MS_HORNER) begin
      mul_a = acc_q;
      mul_b = to_coef(cmd_q.point_x);
    end else begin
      mul_a = rdata_eff;
      mul_b = to_coef(cmd_q.scale_factor);
    end

    case (ctl.ptr)
      PTR_ZERO: ptr_d = '0;
      PTR_DEG:  ptr_d = deg_q;
      PTR_INC:  ptr_d = ptr_q + AW'(1);
      PTR_DEC:  ptr_d = ptr_q - AW'(1);
      default:  ptr_d = ptr_q;
    endcase

    case (ctl.acc)
      ACC_LD:  acc_d = rdata_eff;
      ACC_MAC: acc_d = mul_res + rdata_eff;
      default: acc_d = acc_q;
    endcase

    out_d = '0;
    case (ctl.emit)
      EM_READ: begin
        out_d.status       = rd_err;
        out_d.result_value = rd_err ? '0 : coef_to_out(rdata_eff);
      end
      EM_ACC:  out_d.result_value = coef_to_out(acc_q);
      default: out_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q      <= ST_IDLE;
      deg_q     <= '0;
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      pc_q <= pc_d;
      if (we) begin
        vld_q[waddr] <= 1'b1;
      end
      if (act && ctl.wr == WR_CMD && idx_ok && rd_err) begin
        deg_q <= idx_addr;
      end
      if (act && ctl.emit != EM_NONE) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (act && ctl.ld_cmd) begin
      cmd_q <= in_data_i;
    end
    if (re) begin
      rvld_q <= vld_q[raddr];
    end
    if (act) begin
      ptr_q <= ptr_d;
      acc_q <= acc_d;
    end
    if (act && ctl.emit != EM_NONE) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  pev_ram #(
    .WIDTH (COEF_WIDTH),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  pev_mul #(
    .W (COEF_WIDTH)
  ) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (mul_go),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .busy_o (mul_busy),
    .res_o  (mul_res)
  );

endmodule

// ===== sv/pev_chk.sv =====
// pev_chk: port-level checks for polynomial_eval_engine, bound to the top level
// depends on pev_pkg (payload types)
module pev_chk import pev_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_i,
  input logic     out_valid_i,
  input logic     out_ready_i,
  input pev_out_t out_data_i
);

  // a pending result holds until its transaction completes
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("output result dropped or changed while stalled");

  // one command at a time: no new transaction right after one is taken
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input accepted on back-to-back cycles");

  // a result is only produced while a command is in progress
  a_res_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !$past(in_ready_i))
    else $error("result appeared while the engine was idle");

  // an error result carries a zero value
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.status |-> out_data_i.result_value == '0)
    else $error("error result with non-zero value");

endmodule

bind polynomial_eval_engine pev_chk u_pev_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_i  (in_ready_o),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_i  (out_data_o)
);

// ===== tb/sv/tb_polynomial_eval_engine.sv =====
// tb_polynomial_eval_engine: self-checking bench for the polynomial evaluation engine
// runs a directed command table and then random traffic against an in-bench predictor
// depends on pev_pkg and polynomial_eval_engine
`timescale 1ns / 1ps

module tb_polynomial_eval_engine;
  import pev_pkg::*;

  localparam int unsigned NUM_TERMS   = 16;
  localparam int unsigned NUM_RANDOM  = 1200;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned DRAIN_WAIT  = 40;

  typedef struct {
    pev_in_t  cmd;
    logic     has_exp;
    pev_out_t exp;
  } dir_row_t;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_ready_o;
  pev_in_t  in_data_i;
  logic     out_valid_o;
  logic     out_ready_i;
  pev_out_t out_data_o;

  // predictor state
  logic [31:0] coef_mem [NUM_TERMS];
  logic [3:0]  poly_deg;

  pev_out_t    result_q [$];
  pev_out_t    want;
  dir_row_t    dir_tab [$];

  int unsigned snd_idle;
  int unsigned rcv_idle;
  int unsigned cycles;
  int unsigned errs;
  int unsigned n_checked;
  int unsigned n_wr, n_rd, n_rd_err, n_sc, n_ev;

  polynomial_eval_engine i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still outstanding", $time, result_q.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // works out the result of one command and updates the polynomial
  function automatic pev_out_t eval_command(input pev_in_t c);
    pev_out_t    r;
    logic [31:0] sum;
    logic [31:0] pw;
    r.result_value = '0;
    r.status       = 1'b0;
    case (mode_e'(c.mode))
      MODE_WRITE: begin
        n_wr++;
        if (c.term_index > poly_deg) poly_deg = c.term_index;
        coef_mem[c.term_index] = c.coef_value;
      end
      MODE_READ: begin
        n_rd++;
        if (c.term_index > poly_deg) begin
          r.status = 1'b1;
          n_rd_err++;
        end else begin
          r.result_value = coef_mem[c.term_index];
        end
      end
      MODE_SCALE: begin
        n_sc++;
        for (int i = 0; i <= poly_deg; i++) coef_mem[i] = coef_mem[i] * c.scale_factor;
      end
      default: begin
        n_ev++;
        sum = '0;
        pw  = 32'd1;
        for (int i = 0; i <= poly_deg; i++) begin
          sum = sum + coef_mem[i] * pw;
          pw  = pw * c.point_x;
        end
        r.result_value = sum;
      end
    endcase
    return r;
  endfunction

  // entered and left at a falling edge
  task automatic send_command(input pev_in_t c, input logic has_exp, input pev_out_t exp);
    pev_out_t pred;
    while ($urandom_range(99) < snd_idle) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= c;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pred = eval_command(c);
    result_q.push_back(has_exp ? exp : pred);
    @(negedge clk_i);
  endtask

  // let the engine drain completely before going on
  task automatic hold_until_drained();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (result_q.size() != 0) @(negedge clk_i);
  endtask

  function automatic dir_row_t mk_row(input mode_e m, input logic [3:0] idx,
                                      input logic [31:0] cv, input logic [31:0] px,
                                      input logic [31:0] sf, input logic hx,
                                      input logic [31:0] er, input logic es);
    dir_row_t r;
    r.cmd.mode             = m;
    r.cmd.term_index       = idx;
    r.cmd.coef_value       = cv;
    r.cmd.point_x          = px;
    r.cmd.scale_factor     = sf;
    r.has_exp              = hx;
    r.exp.result_value     = er;
    r.exp.status           = es;
    return r;
  endfunction

  // mixes full-range words with small and boundary values
  function automatic logic [31:0] pick_word();
    case ($urandom_range(3))
      0:       return 32'($signed($urandom_range(8)) - 4);
      1: begin
        case ($urandom_range(3))
          0:       return 32'h8000_0000;
          1:       return 32'h7fff_ffff;
          2:       return 32'hffff_ffff;
          default: return 32'h0;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  function automatic pev_in_t random_command(input int unsigned n);
    pev_in_t     c;
    int unsigned sel;
    int unsigned top;
    c.mode         = 2'($urandom);
    c.term_index   = 4'($urandom);
    c.coef_value   = pick_word();
    c.point_x      = pick_word();
    c.scale_factor = pick_word();
    sel = $urandom_range(99);
    if (sel < 35) c.mode = MODE_WRITE;
    else if (sel < 65) c.mode = MODE_READ;
    else if (sel < 75) c.mode = MODE_SCALE;
    else c.mode = MODE_EVAL;
    // let the degree climb slowly so that short polynomials get exercised too
    if (c.mode == MODE_WRITE && $urandom_range(9) != 0) begin
      top = 1 + n / 60;
      if (top > NUM_TERMS - 1) top = NUM_TERMS - 1;
      c.term_index = 4'($urandom_range(top));
    end
    return c;
  endfunction

  always @(negedge clk_i) begin
    if (rst_ni) out_ready_i <= ($urandom_range(99) >= rcv_idle);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (result_q.size() == 0) begin
        $display("%0t: unexpected transaction, actual value %h status %b", $time,
                 out_data_o.result_value, out_data_o.status);
        errs++;
      end else begin
        want = result_q.pop_front();
        n_checked++;
        if (out_data_o.result_value !== want.result_value) begin
          $display("%0t: result_value mismatch, expected %h actual %h", $time,
                   want.result_value, out_data_o.result_value);
          errs++;
        end
        if (out_data_o.status !== want.status) begin
          $display("%0t: status mismatch, expected %b actual %b", $time,
                   want.status, out_data_o.status);
          errs++;
        end
      end
    end
  end

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_ready_i = 1'b0;
    cycles      = 0;
    errs        = 0;
    n_checked   = 0;
    n_wr        = 0;
    n_rd        = 0;
    n_rd_err    = 0;
    n_sc        = 0;
    n_ev        = 0;
    poly_deg    = '0;
    for (int i = 0; i < NUM_TERMS; i++) coef_mem[i] = '0;
    snd_idle = 32;
    rcv_idle = 74;

    // degree zero after reset, then a short polynomial with boundary coefficients
    dir_tab.push_back(mk_row(MODE_READ,  4'd0,  32'h1234_5678, 32'h0, 32'h0, 1'b1, 32'h0, 1'b0));
    dir_tab.push_back(mk_row(MODE_READ,  4'd15, 32'h0, 32'h0, 32'h0, 1'b1, 32'h0, 1'b1));
    dir_tab.push_back(mk_row(MODE_READ,  4'd1,  32'h0, 32'h0, 32'h0, 1'b1, 32'h0, 1'b1));
    dir_tab.push_back(mk_row(MODE_EVAL,  4'd0,  32'h0, 32'h7fff_ffff, 32'h0, 1'b1, 32'h0, 1'b0));
    dir_tab.push_back(mk_row(MODE_SCALE, 4'd0,  32'h0, 32'h0, 32'd7, 1'b1, 32'h0, 1'b0));
    dir_tab.push_back(mk_row(MODE_WRITE, 4'd0,  32'h7fff_ffff, 32'h0, 32'h0,
                             1'b1, 32'h0, 1'b0));
    dir_tab.push_back(mk_row(MODE_EVAL,  4'd0,  32'h0, 32'h8000_0000, 32'h0,
                             1'b1, 32'h7fff_ffff, 1'b0));
    dir_tab.push_back(mk_row(MODE_READ,  4'd0,  32'h0, 32'h0, 32'h0, 1'b1, 32'h7fff_ffff, 1'b0));
    dir_tab.push_back(mk_row(MODE_WRITE, 4'd3,  32'h8000_0000, 32'h0, 32'h0,
                             1'b1, 32'h0, 1'b0));
    dir_tab.push_back(mk_row(MODE_READ,  4'd2,  32'h0, 32'h0, 32'h0, 1'b1, 32'h0, 1'b0));
    dir_tab.push_back(mk_row(MODE_READ,  4'd4,  32'h0, 32'h0, 32'h0, 1'b1, 32'h0, 1'b1));
    dir_tab.push_back(mk_row(MODE_EVAL,  4'd0,  32'h0, 32'h0, 32'h0, 1'b1, 32'h7fff_ffff, 1'b0));
    dir_tab.push_back(mk_row(MODE_EVAL,  4'd0,  32'h0, 32'd1, 32'h0, 1'b0, 32'h0, 1'b0));
    dir_tab.push_back(mk_row(MODE_EVAL,  4'd0,  32'h0, 32'hffff_ffff, 32'h0, 1'b0, 32'h0, 1'b0));
    dir_tab.push_back(mk_row(MODE_EVAL,  4'd0,  32'h0, 32'h7fff_ffff, 32'h0, 1'b0, 32'h0, 1'b0));
    dir_tab.push_back(mk_row(MODE_SCALE, 4'd0,  32'h0, 32'h0, 32'hffff_ffff, 1'b1, 32'h0, 1'b0));
    dir_tab.push_back(mk_row(MODE_READ,  4'd0,  32'h0, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0));
    dir_tab.push_back(mk_row(MODE_READ,  4'd3,  32'h0, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0));
    // full degree, then scale by the most negative value and by zero
    dir_tab.push_back(mk_row(MODE_WRITE, 4'd15, 32'hffff_ffff, 32'h0, 32'h0,
                             1'b1, 32'h0, 1'b0));
    dir_tab.push_back(mk_row(MODE_SCALE, 4'd0,  32'h0, 32'h0, 32'h8000_0000,
                             1'b1, 32'h0, 1'b0));
    dir_tab.push_back(mk_row(MODE_EVAL,  4'd0,  32'h0, 32'd2, 32'h0, 1'b0, 32'h0, 1'b0));
    dir_tab.push_back(mk_row(MODE_SCALE, 4'd0,  32'h0, 32'h0, 32'h0, 1'b1, 32'h0, 1'b0));
    dir_tab.push_back(mk_row(MODE_EVAL,  4'd0,  32'h0, 32'hffff_fffe, 32'h0, 1'b1, 32'h0, 1'b0));
    dir_tab.push_back(mk_row(MODE_WRITE, 4'd15, 32'd1, 32'h0, 32'h0, 1'b1, 32'h0, 1'b0));
    dir_tab.push_back(mk_row(MODE_EVAL,  4'd0,  32'h0, 32'd2, 32'h0, 1'b0, 32'h0, 1'b0));

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_tab[k]) send_command(dir_tab[k].cmd, dir_tab[k].has_exp, dir_tab[k].exp);

    // the directed rows start from a cleared polynomial, so reset the predictor
    // view only through the commands above; the random part carries on from here
    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n == NUM_RANDOM / 3) begin
        hold_until_drained();
        snd_idle = 74;
        rcv_idle = 32;
      end else if (n == 2 * NUM_RANDOM / 3) begin
        hold_until_drained();
        snd_idle = 0;
        rcv_idle = 0;
      end
      send_command(random_command(n), 1'b0, '0);
    end
    in_valid_i <= 1'b0;

    while (result_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("covered %0d writes, %0d reads (%0d above degree), %0d scales, %0d evaluations",
             n_wr, n_rd, n_rd_err, n_sc, n_ev);
    $display("%0d transactions checked, %0d mismatches", n_checked, errs);
    if (errs == 0 && result_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
